FILE: rtl/core/met_pkg.sv
// Shared types, constants and a helper function of the escape-time block.
package met_pkg;

   localparam int PIX_W       = 12;
   localparam int COUNT_W     = 16;
   localparam int COORD_W     = 32;
   localparam int STEP_W      = 31;
   localparam int PROD_W      = 2 * COORD_W;
   localparam int WIDE_W      = PROD_W + 2;
   localparam int CSR_INDEX_W = 3;
   localparam int CSR_DATA_W  = 32;

   typedef enum logic [CSR_INDEX_W-1:0] {
      CSR_MAX_ITERATIONS = 3'd0,
      CSR_ORIGIN_RE      = 3'd1,
      CSR_ORIGIN_IM      = 3'd2,
      CSR_STEP_RE        = 3'd3,
      CSR_STEP_IM        = 3'd4
   } met_csr_index_type;

   typedef struct packed {
      logic        [COUNT_W-1:0] max_iterations;
      logic signed [COORD_W-1:0] origin_re;
      logic signed [COORD_W-1:0] origin_im;
      logic        [STEP_W-1:0]  step_re;
      logic        [STEP_W-1:0]  step_im;
   } met_cfg_type;

   localparam met_cfg_type CFG_RESET = '{
      max_iterations: 16'd256,
      origin_re:      -32'sd536870912,
      origin_im:      32'sd268435456,
      step_re:        31'd196608,
      step_im:        31'd131072
   };

   // Handshake from the channel logic to the engine.
   typedef struct packed {
      logic start;
      logic ack;
   } met_ctrl_type;

   // Engine status back to the channel logic.
   typedef struct packed {
      logic               idle;
      logic               done;
      logic [COUNT_W-1:0] escape_count;
   } met_status_type;

   localparam logic signed [WIDE_W-1:0] SAT_MAX = WIDE_W'(64'sd2147483647);
   localparam logic signed [WIDE_W-1:0] SAT_MIN = ~SAT_MAX;

   // Clamp a wide signed value into the signed coordinate range.
   function automatic logic signed [COORD_W-1:0] met_sat32(
      input logic signed [WIDE_W-1:0] v);
      logic signed [COORD_W-1:0] r;
      if (v > SAT_MAX) begin
         r = SAT_MAX[COORD_W-1:0];
      end else if (v < SAT_MIN) begin
         r = SAT_MIN[COORD_W-1:0];
      end else begin
         r = v[COORD_W-1:0];
      end
      return r;
   endfunction

endpackage

FILE: rtl/core/met_if.sv
// Channel interfaces for pixel requests, results and register writes.
interface met_req_if;
   import met_pkg::*;
   logic             valid;
   logic             ready;
   logic [PIX_W-1:0] col;
   logic [PIX_W-1:0] row;
   modport source(output valid, output col, output row, input ready);
   modport sink(input valid, input col, input row, output ready);
endinterface

interface met_rsp_if;
   import met_pkg::*;
   logic               valid;
   logic               ready;
   logic [COUNT_W-1:0] escape_count;
   logic [PIX_W-1:0]   col_out;
   logic [PIX_W-1:0]   row_out;
   modport source(output valid, output escape_count, output col_out, output row_out,
                  input ready);
   modport sink(input valid, input escape_count, input col_out, input row_out,
                output ready);
endinterface

interface met_csr_if;
   import met_pkg::*;
   logic                   valid;
   logic                   ready;
   logic [CSR_INDEX_W-1:0] index;
   logic [CSR_DATA_W-1:0]  data;
   modport source(output valid, output index, output data, input ready);
   modport sink(input valid, input index, input data, output ready);
endinterface

FILE: rtl/core/mandelbrot_escape_time.sv
// Top level of the escape-time block: channels, registers and result buffer.
//
// A pixel request transaction on req_chan carries a column and a row. The
// block maps it to c = (origin_re + col*step_re, origin_im - row*step_im)
// and iterates z = z*z + c from z = 0 until |z|^2 exceeds 4 or
// max_iterations iterations have run. One result transaction on rsp_chan
// returns the escape iteration (0 when the point never escaped) with the
// pixel's column and row. A single 32 x 32 multiplier under a small
// sequencer does all the multiplications: ST_PT_RE, ST_PT_IM and ST_PT_END
// form the point, then each iteration runs ST_SQ_RE, ST_SQ_IM, ST_CROSS and
// ST_UPDATE (three products and one update). One pixel is in the sequencer
// at a time, and req_chan.ready returns in the cycle after the result moves
// out. When the receiver stalls, the block still accepts the next pixel;
// that pixel's result waits in the sequencer until the output register
// drains. Register writes on csr_chan are always accepted and should only
// happen while no pixel is in flight. Reset empties the result buffer,
// returns the sequencer to idle and loads every register with its default.
module mandelbrot_escape_time #(
   parameter int FRAC_BITS = 28
) (
   input logic      clock,
   input logic      reset,
   met_req_if.sink  req_chan,
   met_rsp_if.source rsp_chan,
   met_csr_if.sink  csr_chan
);
   import met_pkg::*;

   met_cfg_type    cfg_ff, cfg_in;
   logic [PIX_W-1:0] col_ff, col_in;
   logic [PIX_W-1:0] row_ff, row_in;
   logic             rsp_valid_ff, rsp_valid_in;
   logic [COUNT_W-1:0] rsp_count_ff, rsp_count_in;
   logic [PIX_W-1:0] rsp_col_ff, rsp_col_in;
   logic [PIX_W-1:0] rsp_row_ff, rsp_row_in;

   met_ctrl_type   eng_ctrl;
   met_status_type eng_status;
   logic           req_take;
   logic           out_free;

   // Register file: writes land immediately; unused indexes are dropped.
   assign csr_chan.ready = 1'b1;

   always_comb begin
      cfg_in = cfg_ff;
      if (csr_chan.valid) begin
         case (csr_chan.index)
            CSR_MAX_ITERATIONS: cfg_in.max_iterations = csr_chan.data[COUNT_W-1:0];
            CSR_ORIGIN_RE:      cfg_in.origin_re      = signed'(csr_chan.data);
            CSR_ORIGIN_IM:      cfg_in.origin_im      = signed'(csr_chan.data);
            CSR_STEP_RE:        cfg_in.step_re        = csr_chan.data[STEP_W-1:0];
            CSR_STEP_IM:        cfg_in.step_im        = csr_chan.data[STEP_W-1:0];
            default:            cfg_in = cfg_ff;
         endcase
      end
   end

   // A request is taken whenever the sequencer is free; the pixel
   // coordinates are held here until its result moves to the output.
   assign req_chan.ready = eng_status.idle;
   assign req_take       = req_chan.valid && eng_status.idle;
   assign col_in         = req_take ? req_chan.col : col_ff;
   assign row_in         = req_take ? req_chan.row : row_ff;

   // The finished result moves into the output register once it is empty
   // or being drained in this same cycle.
   assign out_free       = !rsp_valid_ff || rsp_chan.ready;
   assign eng_ctrl.start = req_take;
   assign eng_ctrl.ack   = eng_status.done && out_free;

   always_comb begin
      rsp_valid_in = rsp_valid_ff;
      rsp_count_in = rsp_count_ff;
      rsp_col_in   = rsp_col_ff;
      rsp_row_in   = rsp_row_ff;
      if (rsp_valid_ff && rsp_chan.ready) begin
         rsp_valid_in = 1'b0;
      end
      if (eng_ctrl.ack) begin
         rsp_valid_in = 1'b1;
         rsp_count_in = eng_status.escape_count;
         rsp_col_in   = col_ff;
         rsp_row_in   = row_ff;
      end
   end

   met_engine #(
      .FRAC_BITS(FRAC_BITS)
   ) u_engine (
      .clock  (clock),
      .reset  (reset),
      .cfg    (cfg_ff),
      .col    (col_ff),
      .row    (row_ff),
      .ctrl   (eng_ctrl),
      .status (eng_status)
   );

   always_ff @(posedge clock) begin
      if (reset) begin
         cfg_ff       <= CFG_RESET;
         rsp_valid_ff <= 1'b0;
      end else begin
         cfg_ff       <= cfg_in;
         rsp_valid_ff <= rsp_valid_in;
      end
   end

   always_ff @(posedge clock) begin
      col_ff       <= col_in;
      row_ff       <= row_in;
      rsp_count_ff <= rsp_count_in;
      rsp_col_ff   <= rsp_col_in;
      rsp_row_ff   <= rsp_row_in;
   end

   assign rsp_chan.valid        = rsp_valid_ff;
   assign rsp_chan.escape_count = rsp_count_ff;
   assign rsp_chan.col_out      = rsp_col_ff;
   assign rsp_chan.row_out      = rsp_row_ff;

`ifndef ASSERT_OFF
   a_accept_starts: assert property (@(posedge clock) disable iff (reset)
      (req_chan.valid && req_chan.ready) |=> !eng_status.idle)
      else $error("accepted request did not start the sequencer");

   a_ack_fills_output: assert property (@(posedge clock) disable iff (reset)
      eng_ctrl.ack |=> (rsp_chan.valid && rsp_chan.escape_count == $past(eng_status.escape_count)))
      else $error("finished result did not reach the output register");

   a_rsp_held: assert property (@(posedge clock) disable iff (reset)
      (rsp_chan.valid && !rsp_chan.ready) |=> (rsp_chan.valid
       && $stable(rsp_chan.escape_count) && $stable(rsp_chan.col_out)
       && $stable(rsp_chan.row_out)))
      else $error("result changed while the receiver stalled");
`endif

endmodule

FILE: rtl/core/met_engine.sv
// Sequencer and shared multiplier that compute one pixel's escape count.
module met_engine #(
   parameter int FRAC_BITS = 28
) (
   input  logic                              clock,
   input  logic                              reset,
   input  met_pkg::met_cfg_type              cfg,
   input  logic [met_pkg::PIX_W-1:0]         col,
   input  logic [met_pkg::PIX_W-1:0]         row,
   input  met_pkg::met_ctrl_type             ctrl,
   output met_pkg::met_status_type           status
);
   import met_pkg::*;

   localparam logic signed [WIDE_W-1:0] ESC_LIMIT = WIDE_W'(64'd4 << FRAC_BITS);

   typedef enum logic [2:0] {
      ST_IDLE,
      ST_PT_RE,
      ST_PT_IM,
      ST_PT_END,
      ST_SQ_RE,
      ST_SQ_IM,
      ST_CROSS,
      ST_UPDATE
   } state_type;

   state_type state_ff, state_in;
   logic                      done_ff, done_in;
   logic signed [PROD_W-1:0]  p_ff, p_in;
   logic signed [PROD_W-1:0]  a2_ff, a2_in;
   logic signed [PROD_W-1:0]  b2_ff, b2_in;
   logic signed [COORD_W-1:0] cr_ff, cr_in;
   logic signed [COORD_W-1:0] ci_ff, ci_in;
   logic signed [COORD_W-1:0] zr_ff, zr_in;
   logic signed [COORD_W-1:0] zi_ff, zi_in;
   logic [COUNT_W-1:0]        iter_ff, iter_in;
   logic [COUNT_W-1:0]        count_ff, count_in;

   logic signed [COORD_W-1:0] mul_a;
   logic signed [COORD_W-1:0] mul_b;
   logic signed [PROD_W-1:0]  product;
   logic signed [PROD_W-1:0]  p_shift;
   logic signed [PROD_W-1:0]  cross_shift;
   logic signed [WIDE_W-1:0]  mag_sum;
   logic                      escape;

   // The one multiplier; its operands are chosen by the sequencer.
   always_comb begin
      case (state_ff)
         ST_PT_RE: begin
            mul_a = signed'({{(COORD_W-PIX_W){1'b0}}, col});
            mul_b = signed'({1'b0, cfg.step_re});
         end
         ST_PT_IM: begin
            mul_a = signed'({{(COORD_W-PIX_W){1'b0}}, row});
            mul_b = signed'({1'b0, cfg.step_im});
         end
         ST_SQ_RE: begin
            mul_a = zr_ff;
            mul_b = zr_ff;
         end
         ST_SQ_IM: begin
            mul_a = zi_ff;
            mul_b = zi_ff;
         end
         default: begin
            mul_a = zr_ff;
            mul_b = zi_ff;
         end
      endcase
   end

   assign product     = mul_a * mul_b;
   assign p_shift     = p_ff >>> FRAC_BITS;
   assign cross_shift = p_ff >>> (FRAC_BITS - 1);
   assign mag_sum     = WIDE_W'(a2_ff) + WIDE_W'(b2_ff);
   assign escape      = mag_sum > ESC_LIMIT;

   always_comb begin
      state_in = state_ff;
      done_in  = done_ff;
      p_in     = product;
      a2_in    = a2_ff;
      b2_in    = b2_ff;
      cr_in    = cr_ff;
      ci_in    = ci_ff;
      zr_in    = zr_ff;
      zi_in    = zi_ff;
      iter_in  = iter_ff;
      count_in = count_ff;
      case (state_ff)
         ST_IDLE: begin
            if (done_ff) begin
               if (ctrl.ack) begin
                  done_in = 1'b0;
               end
            end else if (ctrl.start) begin
               state_in = ST_PT_RE;
            end
         end
         ST_PT_RE: begin
            state_in = ST_PT_IM;
         end
         ST_PT_IM: begin
            cr_in    = met_sat32(WIDE_W'(cfg.origin_re) + WIDE_W'(p_ff));
            state_in = ST_PT_END;
         end
         ST_PT_END: begin
            ci_in    = met_sat32(WIDE_W'(cfg.origin_im) - WIDE_W'(p_ff));
            zr_in    = '0;
            zi_in    = '0;
            iter_in  = '0;
            state_in = ST_SQ_RE;
         end
         ST_SQ_RE: begin
            if (iter_ff == cfg.max_iterations) begin
               count_in = '0;
               done_in  = 1'b1;
               state_in = ST_IDLE;
            end else begin
               state_in = ST_SQ_IM;
            end
         end
         ST_SQ_IM: begin
            a2_in    = p_shift;
            state_in = ST_CROSS;
         end
         ST_CROSS: begin
            b2_in    = p_shift;
            state_in = ST_UPDATE;
         end
         ST_UPDATE: begin
            if (escape) begin
               count_in = iter_ff;
               done_in  = 1'b1;
               state_in = ST_IDLE;
            end else begin
               zr_in    = met_sat32(WIDE_W'(a2_ff) - WIDE_W'(b2_ff) + WIDE_W'(cr_ff));
               zi_in    = met_sat32(WIDE_W'(cross_shift) + WIDE_W'(ci_ff));
               iter_in  = iter_ff + COUNT_W'(1);
               state_in = ST_SQ_RE;
            end
         end
         default: begin
            state_in = ST_IDLE;
         end
      endcase
   end

   always_ff @(posedge clock) begin
      p_ff     <= p_in;
      a2_ff    <= a2_in;
      b2_ff    <= b2_in;
      cr_ff    <= cr_in;
      ci_ff    <= ci_in;
      zr_ff    <= zr_in;
      zi_ff    <= zi_in;
      iter_ff  <= iter_in;
      count_ff <= count_in;
      if (reset) begin
         state_ff <= ST_IDLE;
         done_ff  <= 1'b0;
      end else begin
         state_ff <= state_in;
         done_ff  <= done_in;
      end
   end

   assign status.idle         = (state_ff == ST_IDLE) && !done_ff;
   assign status.done         = done_ff;
   assign status.escape_count = count_ff;

`ifndef ASSERT_OFF
   a_start_only_idle: assert property (@(posedge clock) disable iff (reset)
      ctrl.start |-> (state_ff == ST_IDLE && !done_ff))
      else $error("start seen while the engine is busy");

   a_escape_count: assert property (@(posedge clock) disable iff (reset)
      (state_ff == ST_UPDATE && escape) |=> (done_ff && count_ff == $past(iter_ff)))
      else $error("escape did not report the current iteration");

   a_limit_zero: assert property (@(posedge clock) disable iff (reset)
      (state_ff == ST_SQ_RE && iter_ff == cfg.max_iterations)
      |=> (done_ff && count_ff == '0))
      else $error("non-escaping pixel did not report zero");

   a_iter_bound: assert property (@(posedge clock) disable iff (reset)
      (state_ff == ST_SQ_RE || state_ff == ST_SQ_IM || state_ff == ST_CROSS
       || state_ff == ST_UPDATE) |-> (iter_ff <= cfg.max_iterations))
      else $error("iteration counter ran past the limit");
`endif

endmodule
